/* design/tmsf_pkg.sv */
// shared types and constants for the trimmed mean sample filter
package tmsf_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int MAX_WINDOW    = 16;
   localparam int MIN_WINDOW    = 3;

   localparam int READING_BITS  = 16;
   localparam int AVERAGE_BITS  = 16;
   localparam int SAMPLE_CFG_BITS = 5;
   localparam int ERROR_CFG_BITS  = 4;
   localparam int CSR_DATA_BITS   = 5;
   localparam int CSR_INDEX_BITS  = 1;

   localparam int SUM_BITS   = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int COUNT_BITS = $clog2(MAX_WINDOW + 1);
   localparam int DIV_BITS   = $clog2(MAX_WINDOW - 1);
   localparam int ERR_BITS   = ERROR_CFG_BITS + 1;
   localparam int STEP_BITS  = $clog2(SUM_BITS);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_COUNT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ERROR_LIMIT  = 1'b1;

   localparam logic [SAMPLE_CFG_BITS-1:0] SAMPLE_COUNT_RESET = 5'd5;
   localparam logic [ERROR_CFG_BITS-1:0]  ERROR_LIMIT_RESET  = 4'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic fail_result;
      logic div_load;
      logic div_step;
      logic win_result;
   } cmd_type;

   typedef struct packed {
      logic fail_trip;
      logic window_close;
      logic div_done;
      logic out_blocked;
   } status_type;

endpackage

/* design/tmsf_ctrl.sv */
// controller state machine: handshake, window close and divide sequencing
module tmsf_ctrl
   import tmsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.out_blocked && !status.fail_trip &&
                status.window_close) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.out_blocked) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall       = status.out_blocked;
            cmd.accept      = req_valid && !status.out_blocked;
            cmd.fail_result = cmd.accept && status.fail_trip;
         end
         ST_PREP: begin
            cmd.div_load = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_FINISH: begin
            cmd.win_result = !status.out_blocked;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* design/tmsf_datapath.sv */
// datapath: config registers, accumulators, serial divider, result register
module tmsf_datapath
   import tmsf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_write_data,
   input  logic [READING_BITS-1:0]    req_reading,
   input  logic                       req_read_failed,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [AVERAGE_BITS-1:0]    rsp_average,
   output logic                       rsp_sensor_failed,
   input  cmd_type                    cmd,
   output status_type                 status
);

   logic [SAMPLE_CFG_BITS-1:0] sample_count_ff;
   logic [ERROR_CFG_BITS-1:0]  error_limit_ff;

   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [COUNT_BITS-1:0]  good_ff, good_in;
   logic [ERR_BITS-1:0]    err_ff, err_in;

   logic [SUM_BITS-1:0]  quo_ff, quo_in;
   logic [DIV_BITS-1:0]  rem_ff, rem_in;
   logic [DIV_BITS-1:0]  divisor_ff, divisor_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [AVERAGE_BITS-1:0] average_ff, average_in;
   logic                    failed_ff, failed_in;

   logic [SAMPLE_BITS-1:0] sample;
   logic [COUNT_BITS-1:0]  window_n;
   logic [COUNT_BITS-1:0]  good_next;
   logic [ERR_BITS-1:0]    err_next;
   logic [SUM_BITS-1:0]    total;
   logic [DIV_BITS:0]      rem_shift;
   logic                   quo_bit;

   assign sample    = SAMPLE_BITS'(req_reading);
   assign good_next = good_ff + 1'b1;
   assign err_next  = err_ff + 1'b1;

   always_comb begin
      if (int'(sample_count_ff) < MIN_WINDOW) begin
         window_n = COUNT_BITS'(MIN_WINDOW);
      end else if (int'(sample_count_ff) > MAX_WINDOW) begin
         window_n = COUNT_BITS'(MAX_WINDOW);
      end else begin
         window_n = COUNT_BITS'(sample_count_ff);
      end
   end

   assign status.fail_trip    = req_read_failed && (err_next > ERR_BITS'(error_limit_ff));
   assign status.window_close = !req_read_failed && (good_next >= window_n);
   assign status.div_done     = (step_ff == STEP_BITS'(SUM_BITS - 1));
   assign status.out_blocked  = rsp_valid_ff && rsp_stall;

   assign total     = sum_ff - SUM_BITS'(max_ff) - SUM_BITS'(min_ff);
   assign rem_shift = {rem_ff, quo_ff[SUM_BITS-1]};
   assign quo_bit   = (rem_shift >= {1'b0, divisor_ff});

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SAMPLE_COUNT_RESET;
         error_limit_ff  <= ERROR_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SAMPLE_COUNT: sample_count_ff <= csr_write_data;
            CSR_ERROR_LIMIT:  error_limit_ff  <= ERROR_CFG_BITS'(csr_write_data);
            default: begin
            end
         endcase
      end
   end

   // window accumulators
   always_comb begin
      sum_in  = sum_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      good_in = good_ff;
      err_in  = err_ff;
      if (cmd.fail_result || cmd.win_result) begin
         sum_in  = '0;
         min_in  = '1;
         max_in  = '0;
         good_in = '0;
         err_in  = '0;
      end else if (cmd.accept) begin
         if (req_read_failed) begin
            err_in = err_next;
         end else begin
            sum_in  = sum_ff + SUM_BITS'(sample);
            good_in = good_next;
            if (sample < min_ff) begin
               min_in = sample;
            end
            if (sample > max_ff) begin
               max_in = sample;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         min_ff  <= '1;
         max_ff  <= '0;
         good_ff <= '0;
         err_ff  <= '0;
      end else begin
         sum_ff  <= sum_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
         good_ff <= good_in;
         err_ff  <= err_in;
      end
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      if (cmd.div_load) begin
         quo_in     = total;
         rem_in     = '0;
         divisor_in = DIV_BITS'(good_ff - COUNT_BITS'(2));
         step_in    = '0;
      end else if (cmd.div_step) begin
         quo_in  = {quo_ff[SUM_BITS-2:0], quo_bit};
         step_in = step_ff + 1'b1;
         if (quo_bit) begin
            rem_in = DIV_BITS'(rem_shift - {1'b0, divisor_ff});
         end else begin
            rem_in = rem_shift[DIV_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      average_in   = average_ff;
      failed_in    = failed_ff;
      if (cmd.fail_result) begin
         rsp_valid_in = 1'b1;
         average_in   = '0;
         failed_in    = 1'b1;
      end else if (cmd.win_result) begin
         rsp_valid_in = 1'b1;
         average_in   = AVERAGE_BITS'(quo_ff);
         failed_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      average_ff <= average_in;
      failed_ff  <= failed_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_average       = average_ff;
   assign rsp_sensor_failed = failed_ff;

endmodule

/* design/trimmed_mean_sample_filter.sv */
// top level: one reading per cycle accumulates when not stalled; a window-closing reading
// starts a serial divide of SUM_BITS steps (20 at default widths) that yields its result;
// a failure result appears in the cycle after the failed reading's transfer
// the request side stalls during the divide and while a result is held by rsp_stall
// synchronous active-high reset clears control, accumulators and restores register
// defaults (sample_count 5, error_limit 4)
module trimmed_mean_sample_filter
   import tmsf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [READING_BITS-1:0]    req_reading,
   input  logic                       req_read_failed,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [AVERAGE_BITS-1:0]    rsp_average,
   output logic                       rsp_sensor_failed
);

   cmd_type    cmd;
   status_type status;

   tmsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tmsf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_reading       (req_reading),
      .req_read_failed   (req_read_failed),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_average       (rsp_average),
      .rsp_sensor_failed (rsp_sensor_failed),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

/* design/tmsf_checker.sv */
// port-level checker for the trimmed mean sample filter, with its bind
module tmsf_checker
   import tmsf_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    req_read_failed,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [AVERAGE_BITS-1:0] rsp_average,
   input logic                    rsp_sensor_failed
);

   logic req_xfer;
   logic rsp_held;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_held = rsp_valid && rsp_stall;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // failure result carries a zero average
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sensor_failed |-> rsp_average == '0)
      else $error("failure result with nonzero average");

   // a held result blocks new readings
   a_held_stalls: assert property (@(posedge clock) disable iff (reset)
      rsp_held |-> req_stall)
      else $error("reading taken while result held");

   // a failed read never yields an average result next cycle
   a_fail_no_avg: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_read_failed && !rsp_held |=> !rsp_valid || rsp_sensor_failed)
      else $error("average result after failed read");

   // a good read never yields a result in the next cycle
   a_good_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !req_read_failed && !rsp_held |=> !rsp_valid)
      else $error("result one cycle after good read");

endmodule

bind trimmed_mean_sample_filter tmsf_checker u_tmsf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_read_failed   (req_read_failed),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_average       (rsp_average),
   .rsp_sensor_failed (rsp_sensor_failed)
);

/* tb/sv/tb_trimmed_mean_sample_filter.sv */
`timescale 1ns / 1ps
// self-checking testbench for the trimmed mean sample filter: windows, failures, register changes
module tb_trimmed_mean_sample_filter;
   import tmsf_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE_WAIT  = 40;
   localparam int PHASE_COUNT  = 20;
   localparam int PHASE_ITEMS  = 84;
   localparam int CALM_PHASES  = 3;

   typedef struct packed {
      logic [AVERAGE_BITS-1:0] average;
      logic                    sensor_failed;
   } filter_result_type;

   class window_scoreboard;
      logic [SAMPLE_CFG_BITS-1:0] sample_count;
      logic [ERROR_CFG_BITS-1:0]  error_limit;
      logic [SUM_BITS-1:0]        running_sum;
      logic [READING_BITS-1:0]    smallest_seen;
      logic [READING_BITS-1:0]    largest_seen;
      logic [COUNT_BITS-1:0]      good_count;
      logic [ERR_BITS-1:0]        error_count;
      filter_result_type          pending_results[$];
      int                         failures;

      function new();
         sample_count = SAMPLE_COUNT_RESET;
         error_limit  = ERROR_LIMIT_RESET;
         failures     = 0;
         restart_window();
      endfunction

      function void restart_window();
         running_sum   = '0;
         smallest_seen = '1;
         largest_seen  = '0;
         good_count    = '0;
         error_count   = '0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] data);
         if (index == CSR_SAMPLE_COUNT) begin
            sample_count = data[SAMPLE_CFG_BITS-1:0];
         end else if (index == CSR_ERROR_LIMIT) begin
            error_limit = data[ERROR_CFG_BITS-1:0];
         end
      endfunction

      function int window_size();
         int n;
         n = sample_count;
         if (n < MIN_WINDOW) n = MIN_WINDOW;
         if (n > MAX_WINDOW) n = MAX_WINDOW;
         return n;
      endfunction

      function void note_reading(logic [READING_BITS-1:0] reading, logic read_failed);
         filter_result_type   res;
         logic [SUM_BITS-1:0] total;
         if (read_failed) begin
            error_count = error_count + 1'b1;
            if (error_count > error_limit) begin
               res.average       = '0;
               res.sensor_failed = 1'b1;
               pending_results.push_back(res);
               restart_window();
            end
            return;
         end
         running_sum = running_sum + reading;
         if (reading < smallest_seen) smallest_seen = reading;
         if (reading > largest_seen) largest_seen = reading;
         good_count = good_count + 1'b1;
         if (good_count < window_size()) return;
         total             = running_sum - largest_seen - smallest_seen;
         res.average       = AVERAGE_BITS'(total / (good_count - 2'd2));
         res.sensor_failed = 1'b0;
         pending_results.push_back(res);
         restart_window();
      endfunction

      function void check_result(filter_result_type got);
         filter_result_type want;
         if (pending_results.size() == 0) begin
            $error("unexpected result: average %0d, sensor_failed %0d",
                   got.average, got.sensor_failed);
            failures++;
            return;
         end
         want = pending_results.pop_front();
         if (got.average !== want.average) begin
            $error("average: expected %0d, actual %0d", want.average, got.average);
            failures++;
         end
         if (got.sensor_failed !== want.sensor_failed) begin
            $error("sensor_failed: expected %0d, actual %0d",
                   want.sensor_failed, got.sensor_failed);
            failures++;
         end
      endfunction

      function int pending_count();
         return pending_results.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [READING_BITS-1:0]   req_reading = '0;
   logic                      req_read_failed = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [AVERAGE_BITS-1:0]   rsp_average;
   logic                      rsp_sensor_failed;

   window_scoreboard board = new();
   int  cycle_count = 0;
   int  idle_pct = 0;
   int  stall_left = 0;
   bit  calm = 1'b0;

   trimmed_mean_sample_filter u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_reading       (req_reading),
      .req_read_failed   (req_read_failed),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_average       (rsp_average),
      .rsp_sensor_failed (rsp_sensor_failed)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         cycle_count <= cycle_count + 1;
         if (!reset && rsp_valid && !rsp_stall) begin
            board.check_result('{rsp_average, rsp_sensor_failed});
         end
      end
   end

   // result side back-pressure in short bursts
   always @(negedge clock) begin
      if (calm || reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(99) < idle_pct) begin
         stall_left = $urandom_range(5, 0);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_reading(input logic [READING_BITS-1:0] reading, input logic failed);
      req_valid       <= 1'b1;
      req_reading     <= reading;
      req_read_failed <= failed;
      do @(posedge clock); while (req_stall);
      board.note_reading(reading, failed);
      @(negedge clock);
      if (!calm && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending_count() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.write_register(index, data);
      @(negedge clock);
   endtask

   function automatic logic [READING_BITS-1:0] pick_reading();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return READING_BITS'($urandom_range(15));
         3:       return READING_BITS'($urandom_range(65535, 65520));
         default: return READING_BITS'($urandom);
      endcase
   endfunction

   initial begin
      int                         fail_pct;
      logic [CSR_DATA_BITS-1:0]   count_value;
      logic [ERROR_CFG_BITS-1:0]  limit_value;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // extremes in one window, a failed transfer in the middle is ignored
      send_reading(16'h0000, 1'b0);
      send_reading(16'hFFFF, 1'b1);
      send_reading(16'hFFFF, 1'b0);
      send_reading(16'h8000, 1'b0);
      send_reading(16'h0001, 1'b0);
      send_reading(16'hFFFE, 1'b0);
      repeat (5) send_reading(16'hFFFF, 1'b0);
      // failure after partial window
      send_reading(16'h1234, 1'b0);
      repeat (5) send_reading(READING_BITS'($urandom), 1'b1);
      // shrink the window below the collected count
      settle();
      write_csr(CSR_SAMPLE_COUNT, 5'd16);
      repeat (6) send_reading(pick_reading(), 1'b0);
      settle();
      write_csr(CSR_SAMPLE_COUNT, 5'd3);
      send_reading(pick_reading(), 1'b0);
      settle();
      write_csr(CSR_ERROR_LIMIT, 5'd0);
      send_reading(16'hFFFF, 1'b1);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         settle();
         case (phase)
            0: begin
               count_value = 5'd0;
               limit_value = 4'd15;
            end
            1: begin
               count_value = 5'd31;
               limit_value = 4'd0;
            end
            default: begin
               case ($urandom_range(7))
                  0:       count_value = 5'd0;
                  1:       count_value = 5'd2;
                  2:       count_value = 5'd3;
                  3:       count_value = 5'd16;
                  4:       count_value = CSR_DATA_BITS'($urandom_range(31, 17));
                  default: count_value = CSR_DATA_BITS'($urandom_range(31));
               endcase
               limit_value = ERROR_CFG_BITS'($urandom_range(15));
            end
         endcase
         if (phase < 2 || $urandom_range(3) != 0) begin
            write_csr(CSR_SAMPLE_COUNT, count_value);
         end
         if (phase < 2 || $urandom_range(1) != 0) begin
            write_csr(CSR_ERROR_LIMIT, {1'($urandom_range(1)), limit_value});
         end
         calm = (phase >= PHASE_COUNT - CALM_PHASES);
         case ($urandom_range(2))
            0:       idle_pct = 0;
            1:       idle_pct = 15;
            default: idle_pct = 40;
         endcase
         case ($urandom_range(3))
            0:       fail_pct = 0;
            1:       fail_pct = 3;
            2:       fail_pct = 10;
            default: fail_pct = 35;
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            send_reading(pick_reading(), $urandom_range(99) < fail_pct);
         end
      end

      req_valid <= 1'b0;
      while (board.pending_count() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
      if (board.failures == 0 && board.pending_count() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* trimmed_mean_sample_filter.f */
design/tmsf_pkg.sv
design/tmsf_ctrl.sv
design/tmsf_datapath.sv
design/trimmed_mean_sample_filter.sv
design/tmsf_checker.sv
tb/sv/tb_trimmed_mean_sample_filter.sv
